>>> rtl/core/rocc_pkg.sv
// rocc_pkg: sizes, opcodes and register indexes of the occupancy map block
// used by rect_occupancy_map_unit; no dependencies
`default_nettype none

package rocc_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;

   localparam int ROW_ADDR_W  = $clog2(MAX_ROWS);
   localparam int CNT_W       = 7;
   localparam int COORD_W     = 8;
   localparam int SUM_W       = 10;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CHECK   = 2'd0,
      OP_OCCUPY  = 2'd1,
      OP_RELEASE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_COLS = 1'b0,
      CSR_GRID_ROWS = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/core/rocc_ram.sv
// rocc_ram: generic simple dual port RAM, one write and one registered read port
// no dependencies
`default_nettype none

module rocc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/rect_occupancy_map_unit.sv
// rect_occupancy_map_unit: occupancy bitmap, one row word per RAM entry,
// read-modify-write of one row per cycle; uses rocc_pkg and rocc_ram
//
//   port group   direction   content
//   req_*        in          opcode, area_col, area_row, area_width, area_height
//   rsp_*        out         area_free, done_opcode
//   csr_*        in          write of grid_cols (index 0) or grid_rows (index 1)
//
// an item passes setup, run over its rows, drain and finish; only finish when
// no row is touched; the single RAM read port walks one row word per cycle
// reset clears the row valid flags at once, so no clearing pass is needed
// a new item is taken once the previous result sits in the output register;
// a stalled result holds the walk at its last step
`default_nettype none

module rect_occupancy_map_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [rocc_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic signed [rocc_pkg::COORD_W-1:0]   req_area_col,
   input  wire logic signed [rocc_pkg::COORD_W-1:0]   req_area_row,
   input  wire logic [rocc_pkg::CNT_W-1:0]            req_area_width,
   input  wire logic [rocc_pkg::CNT_W-1:0]            req_area_height,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_area_free,
   output logic [rocc_pkg::OPCODE_W-1:0]              rsp_done_opcode,
   input  wire logic                                  csr_write_en,
   input  wire logic [rocc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [rocc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import rocc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_RUN,
      S_DRAIN,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      grid_cols_ff, grid_cols_in;
   logic [CNT_W-1:0]      grid_rows_ff, grid_rows_in;
   logic [MAX_ROWS-1:0]   row_valid_ff, row_valid_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [ROW_ADDR_W-1:0] rd_row_ff, rd_row_in;
   logic [ROW_ADDR_W-1:0] pend_row_ff, pend_row_in;
   logic [CNT_W-1:0]      row_end_ff, row_end_in;
   logic [CNT_W-1:0]      col_start_ff, col_start_in;
   logic [CNT_W-1:0]      col_end_ff, col_end_in;
   logic [MAX_COLS-1:0]   mask_ff, mask_in;
   logic                  base_free_ff, base_free_in;
   logic                  acc_ff, acc_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  rsp_free_ff, rsp_free_in;
   logic [OPCODE_W-1:0]   rsp_op_ff, rsp_op_in;

   logic signed [SUM_W-1:0] row_s, col_s, row_sum, col_sum;
   logic signed [SUM_W-1:0] rows_s, cols_s, row_lo, row_hi, col_lo, col_hi;
   logic                    nonempty, clip_nonempty, in_bounds, walk;
   logic                    accept, last_row, do_write, rsp_load;
   logic [MAX_COLS-1:0]     ram_q, row_word, wr_word;

   rocc_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (pend_row_ff),
      .wr_data (wr_word),
      .rd_en   (state_ff == S_RUN),
      .rd_addr (rd_row_ff),
      .rd_data (ram_q)
   );

   // request decode and clipping
   always_comb begin
      row_s   = SUM_W'(req_area_row);
      col_s   = SUM_W'(req_area_col);
      row_sum = row_s + $signed({{(SUM_W-CNT_W){1'b0}}, req_area_height});
      col_sum = col_s + $signed({{(SUM_W-CNT_W){1'b0}}, req_area_width});
      rows_s  = $signed({{(SUM_W-CNT_W){1'b0}}, grid_rows_ff});
      cols_s  = $signed({{(SUM_W-CNT_W){1'b0}}, grid_cols_ff});
      row_lo  = (row_s < 0) ? '0 : row_s;
      col_lo  = (col_s < 0) ? '0 : col_s;
      row_hi  = (row_sum > rows_s) ? rows_s : row_sum;
      col_hi  = (col_sum > cols_s) ? cols_s : col_sum;
      nonempty      = (req_area_width != '0) && (req_area_height != '0);
      clip_nonempty = nonempty && (row_lo < row_hi) && (col_lo < col_hi);
      in_bounds     = (row_s >= 0) && (col_s >= 0) && (row_sum <= rows_s)
                      && (col_sum <= cols_s);
      case (req_opcode)
         OP_CHECK:   walk = nonempty && in_bounds;
         OP_OCCUPY:  walk = clip_nonempty;
         OP_RELEASE: walk = clip_nonempty;
         default:    walk = 1'b0;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign last_row  = (CNT_W'({1'b0, rd_row_ff}) + CNT_W'(1)) == row_end_ff;
   assign row_word  = rd_valid_ff ? ram_q : '0;
   assign do_write  = pend_ff && ((op_ff == OP_OCCUPY) || (op_ff == OP_RELEASE));
   assign wr_word   = (op_ff == OP_OCCUPY) ? (row_word | mask_ff) : (row_word & ~mask_ff);
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      row_valid_in = row_valid_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      rd_row_in    = rd_row_ff;
      pend_row_in  = rd_row_ff;
      row_end_in   = row_end_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      mask_in      = mask_ff;
      base_free_in = base_free_ff;
      acc_in       = acc_ff;
      rd_valid_in  = row_valid_ff[rd_row_ff];
      rsp_free_in  = rsp_free_ff;
      rsp_op_in    = rsp_op_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_COLS: grid_cols_in = (csr_wdata > CNT_W'(MAX_COLS)) ?
                                          CNT_W'(MAX_COLS) : csr_wdata;
            CSR_GRID_ROWS: grid_rows_in = (csr_wdata > CNT_W'(MAX_ROWS)) ?
                                          CNT_W'(MAX_ROWS) : csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (pend_ff) begin
         if (op_ff == OP_CHECK) begin
            acc_in = acc_ff | ((row_word & mask_ff) != '0);
         end
         if (do_write) begin
            row_valid_in[pend_row_ff] = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_opcode;
               rd_row_in    = row_lo[ROW_ADDR_W-1:0];
               row_end_in   = row_hi[CNT_W-1:0];
               col_start_in = col_lo[CNT_W-1:0];
               col_end_in   = col_hi[CNT_W-1:0];
               acc_in       = 1'b0;
               base_free_in = (req_opcode == OP_CHECK) && (!nonempty || in_bounds);
               state_in     = walk ? S_SETUP : S_FIN;
            end
         end
         S_SETUP: begin
            for (int i = 0; i < MAX_COLS; i++) begin
               mask_in[i] = (CNT_W'(i) >= col_start_ff) && (CNT_W'(i) < col_end_ff);
            end
            state_in = S_RUN;
         end
         S_RUN: begin
            pend_in   = 1'b1;
            rd_row_in = rd_row_ff + ROW_ADDR_W'(1);
            if (last_row) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_free_in  = base_free_ff && !acc_ff;
               rsp_op_in    = op_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grid_cols_ff <= '0;
         grid_rows_ff <= '0;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         row_valid_ff <= row_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      rd_row_ff    <= rd_row_in;
      pend_row_ff  <= pend_row_in;
      row_end_ff   <= row_end_in;
      col_start_ff <= col_start_in;
      col_end_ff   <= col_end_in;
      mask_ff      <= mask_in;
      base_free_ff <= base_free_in;
      acc_ff       <= acc_in;
      rd_valid_ff  <= rd_valid_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_op_ff    <= rsp_op_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_area_free   = rsp_free_ff;
   assign rsp_done_opcode = rsp_op_ff;

endmodule

`default_nettype wire
